[src/int2dec_pkg.sv]
// shared constants for the integer to decimal ascii converter
package int2dec_pkg;

  // ascii codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // a 32-bit magnitude has at most ten decimal digits
  localparam int DIG_DEPTH = 10;
  localparam int DIG_IDX_W = $clog2(DIG_DEPTH);
  localparam int DIG_CNT_W = $clog2(DIG_DEPTH + 1);

  // divide by ten: q = (mag * RECIP10) >> RECIP_SHIFT, exact for all 32-bit mag
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // result tdata layout
  localparam int M_TDATA_W = 16;

endpackage

[src/integer_to_decimal_ascii_top.sv]
// integer to decimal ascii converter: shared divide-by-ten unit and char sequencer
// steps: take the value, then for each decimal digit the divide unit multiplies
//   by the reciprocal and then forms quotient and remainder, then the string is
//   decided, then one character per cycle goes out while the sink is ready
// the block takes no new item until the last character of the previous one is
//   in the output register; rst_ni clears the sequencer and output valid only
module integer_to_decimal_ascii_top
  import int2dec_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [31:0] value (signed), [35:32] digit_limit, [39:36] zero
  input  logic [39:0]          s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] char_out, [11:8] char_count, [15:12] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // last_char
  output logic                 m_axis_tlast_o,
  // [0] conv_status
  output logic                 m_axis_tuser_o
);

  localparam int LimW = $clog2(MAX_DIGITS + 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [31:0]          mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic [LimW-1:0]      limit_q, limit_d;
  logic [63:0]          prod_q;
  logic [DIG_CNT_W-1:0] ndig_q, ndig_d;
  logic [3:0]           idx_q, idx_d;
  logic [3:0]           count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic [3:0]           digits_q [DIG_DEPTH];

  logic                 m_valid_q;
  logic [7:0]           m_char_q;
  logic [3:0]           m_count_q;
  logic                 m_last_q;
  logic                 m_status_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 emit_load;
  logic [3:0]           lim_in;
  logic [28:0]          quot;
  logic [31:0]          quot_x10;
  logic [31:0]          rem_full;
  logic [DIG_IDX_W-1:0] rd_idx;
  logic [DIG_CNT_W-1:0] rd_diff;
  logic [7:0]           emit_char;
  logic                 emit_last;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign emit_load       = (state_q == ST_EMIT) && out_free;
  assign lim_in          = s_axis_tdata_i[35:32];

  // quotient and remainder from the registered product
  assign quot     = prod_q[63:RECIP_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = mag_q - quot_x10;

  // character selection for the current emit position
  assign rd_diff   = ndig_q - DIG_CNT_W'(idx_q);
  assign rd_idx    = (idx_q == 4'd0) ? '0 : DIG_IDX_W'(rd_diff);
  assign emit_last = (idx_q == count_q - 4'd1);

  always_comb begin
    if (ovf_q) begin
      emit_char = CH_STAR;
    end else if (idx_q == 4'd0) begin
      emit_char = neg_q ? CH_MINUS : CH_PLUS;
    end else begin
      emit_char = CH_ZERO + {4'b0000, digits_q[rd_idx]};
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    limit_d = limit_q;
    ndig_d  = ndig_q;
    idx_d   = idx_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_d   = s_axis_tdata_i[31];
          mag_d   = s_axis_tdata_i[31] ? (32'd0 - s_axis_tdata_i[31:0])
                                       : s_axis_tdata_i[31:0];
          limit_d = (lim_in == 4'd0 || int'(lim_in) > MAX_DIGITS) ?
                    LimW'(MAX_DIGITS) : LimW'(lim_in);
          ndig_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        mag_d  = {3'b000, quot};
        ndig_d = ndig_q + DIG_CNT_W'(1);
        if (quot == '0 || int'(ndig_q) + 1 >= DIG_DEPTH) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        ovf_d   = int'(ndig_q) > int'(limit_q);
        count_d = ovf_d ? 4'(int'(limit_q) + 1) : 4'(int'(ndig_q) + 1);
        idx_d   = 4'd0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          idx_d = idx_q + 4'd1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    limit_q <= limit_d;
    ndig_q  <= ndig_d;
    idx_q   <= idx_d;
    count_q <= count_d;
    ovf_q   <= ovf_d;
    if (state_q == ST_MUL) begin
      prod_q <= {32'd0, mag_q} * {32'd0, RECIP10};
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      digits_q[DIG_IDX_W'(ndig_q)] <= rem_full[3:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      m_char_q   <= emit_char;
      m_count_q  <= count_q;
      m_last_q   <= emit_last;
      m_status_q <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, m_count_q, m_char_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_status_q;

  // digit count never runs past the store
  a_ndig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ndig_q) <= DIG_DEPTH || state_q == ST_IDLE || state_q == ST_MUL)
    else $error("digit count past store depth");

  // an accepted item starts the divide unit
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_MUL)
    else $error("accepted item did not start divide");

  // emit position stays within the string
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> idx_q < count_q)
    else $error("emit index past character count");

  // a good conversion ends on a decimal digit
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_last_q && !m_status_q) |->
      (m_char_q >= CH_ZERO && m_char_q <= CH_ZERO + 8'd9))
    else $error("good conversion does not end on a digit");

  // the remainder from the divide unit is a single decimal digit
  a_rem_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_full < 32'd10)
    else $error("divide remainder out of range");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the integer to decimal ascii converter
`timescale 1ns / 1ps

module tb_top;
  import int2dec_pkg::*;

  localparam int CONV_MAX_DIGITS = 10;
  localparam int RANDOM_ITEMS    = 400;
  localparam int STEADY_ITEMS    = 50;

  // one character of a conversion as the sink should see it
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic [3:0] char_count;
    logic       overflow;
  } ascii_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  ascii_char_t pending_chars[$];
  logic        idle_on = 1'b1;
  int          sink_stall = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          chars_seen = 0;
  int          overflow_items = 0;

  integer_to_decimal_ascii_top #(
    .MAX_DIGITS(CONV_MAX_DIGITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // expected character string for one value and digit limit
  function automatic void predict_chars(input logic [31:0] raw, input logic [3:0] lim);
    logic [31:0] mag;
    logic [3:0]  dig[12];
    int          ndig;
    int          eff_lim;
    int          cnt;
    ascii_char_t c;
    mag = raw[31] ? (32'd0 - raw) : raw;
    eff_lim = (lim < 1 || lim > CONV_MAX_DIGITS) ? CONV_MAX_DIGITS : int'(lim);
    ndig = 0;
    do begin
      dig[ndig] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      ndig++;
    end while (mag != 0 && ndig < 12);
    if (ndig > eff_lim) begin
      // too many digits: star fill, no sign
      cnt = eff_lim + 1;
      overflow_items++;
      for (int i = 0; i < cnt; i++) begin
        c.char_code  = CH_STAR;
        c.last_char  = (i + 1 == cnt);
        c.char_count = 4'(cnt);
        c.overflow   = 1'b1;
        pending_chars.push_back(c);
      end
    end else begin
      cnt = ndig + 1;
      c.char_code  = raw[31] ? CH_MINUS : CH_PLUS;
      c.last_char  = 1'b0;
      c.char_count = 4'(cnt);
      c.overflow   = 1'b0;
      pending_chars.push_back(c);
      for (int i = ndig; i > 0; i--) begin
        c.char_code = CH_ZERO + 8'(dig[i-1]);
        c.last_char = (i == 1);
        pending_chars.push_back(c);
      end
    end
  endfunction

  // one input transfer; tvalid stays high so a following item can go back to back
  task automatic send_item(input logic [31:0] value, input logic [3:0] lim);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    predict_chars(value, lim);
    items_sent++;
    s_axis_tdata  <= {4'b0000, lim, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sink side: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall    <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_stall    <= $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each output transfer with the oldest expected character
  always @(posedge clk_i) begin
    ascii_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected char", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata[7:0] !== want.char_code)
          report_mismatch("char_out", 32'(m_axis_tdata[7:0]), 32'(want.char_code));
        if (m_axis_tdata[11:8] !== want.char_count)
          report_mismatch("char_count", 32'(m_axis_tdata[11:8]), 32'(want.char_count));
        if (m_axis_tdata[15:12] !== 4'b0000)
          report_mismatch("tdata pad", 32'(m_axis_tdata[15:12]), 32'd0);
        if (m_axis_tlast !== want.last_char)
          report_mismatch("last_char", 32'(m_axis_tlast), 32'(want.last_char));
        if (m_axis_tuser !== want.overflow)
          report_mismatch("conv_status", 32'(m_axis_tuser), 32'(want.overflow));
      end
    end
  end

  // zero, one-digit limits, the extremes of value and limit
  task automatic test_edges();
    send_item(32'd0, 4'd0);
    send_item(32'd0, 4'd1);
    send_item(32'd1, 4'd1);
    send_item(32'd9, 4'd1);
    send_item(-32'sd1, 4'd1);
    send_item(32'h7FFF_FFFF, 4'd10);
    send_item(32'h8000_0000, 4'd0);
    send_item(32'h8000_0000, 4'd15);
    send_item(32'h8000_0000, 4'd11);
    send_item(32'd1000000000, 4'd10);
    send_item(32'd999999999, 4'd9);
    send_item(32'd12345, 4'd12);
    send_item(-32'sd7, 4'd2);
    send_item(32'd100, 4'd3);
  endtask

  // magnitudes just past the digit limit give star fill; the last item is -1 at the default limit
  task automatic test_overflow();
    send_item(32'd10, 4'd1);
    send_item(-32'sd10, 4'd1);
    send_item(32'h7FFF_FFFF, 4'd9);
    send_item(32'h8000_0000, 4'd9);
    send_item(32'd1000000000, 4'd9);
    send_item(32'd12345, 4'd4);
    send_item(-32'sd12345, 4'd4);
    send_item(32'd100, 4'd2);
    send_item(32'hFFFF_FFFF, 4'd0);
  endtask

  // random value with a chosen number of digits, limit mostly near that count
  task automatic send_random_item();
    int          ndig;
    longint      lo;
    longint      hi;
    longint      mag;
    logic        neg;
    logic [31:0] value;
    int          lim;
    if ($urandom_range(0, 3) == 0) begin
      value = $urandom;
      lim   = $urandom_range(0, 15);
    end else begin
      ndig = $urandom_range(1, 10);
      neg  = 1'($urandom_range(0, 1));
      lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
      hi   = (ndig == 10) ? (neg ? 64'd2147483648 : 64'd2147483647) : 10 ** ndig - 1;
      mag  = lo + (longint'($urandom) % (hi - lo + 1));
      value = neg ? 32'(-mag) : 32'(mag);
      if ($urandom_range(0, 9) < 7) begin
        lim = ndig + $urandom_range(0, 2) - 1;
        if (lim > 15) lim = 15;
      end else begin
        lim = $urandom_range(0, 15);
      end
    end
    send_item(value, 4'(lim));
  endtask

  // random items with idling, one stretch without
  task automatic test_random();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 150 && n < 200);
      send_random_item();
    end
  endtask

  // last part of the run at full rate on both sides
  task automatic test_steady();
    idle_on = 1'b0;
    for (int n = 0; n < STEADY_ITEMS; n++) send_random_item();
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_overflow();
    test_random();
    test_steady();
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_chars.size() != 0)
      report_mismatch("chars never arrived", 32'(pending_chars.size()), 32'd0);
    $display("covered %0d conversions (%0d star filled), %0d chars checked",
             items_sent, overflow_items, chars_seen);
    $display("value and limit extremes, most negative value, random stalls on both sides");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
